/* design/ssed_pkg.sv */
package ssed_pkg;

    localparam int ROW_BITS     = 12;
    localparam int COL_OUT_BITS = 11;
    localparam int HEIGHT_BITS  = 13;
    localparam int MAX_HEIGHT   = 4096;
    localparam int FW_BITS      = 12;
    localparam int THR_BITS     = 15;
    localparam int CFG_IDX_BITS = 2;
    localparam int OUT_DATA_BITS = 24;

    localparam logic [FW_BITS-1:0]     FRAME_WIDTH_RST  = 12'd640;
    localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic [THR_BITS-1:0]    THRESHOLD_RST    = 15'd1;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SMALL_THRESHOLD = 2'd2;

    typedef enum logic [1:0] {
        KIND_MAX  = 2'd0,
        KIND_MIN  = 2'd1,
        KIND_BOTH = 2'd2
    } t_kind;

    typedef struct packed {
        logic                valid;
        logic                res;
        logic                shift;
        logic                write;
        logic                zero_bot;
        logic                use_pre;
        logic                lmir;
        logic                rmir;
        logic                tmir;
        logic                bmir;
        logic                last;
        logic [ROW_BITS-1:0] rm;
    } t_s1_ctrl;

endpackage

/* design/ssed_ram.sv */
module ssed_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* design/scale_space_extremum_detect.sv */
// an accepted item passes through the stage 1 registers and then the output register, which holds its result
// throughput: one item per cycle; input stalls only while a held result blocks the output register
// the line store is one dual-port ram with registered read, read at accept, written as the item leaves stage 1
// reset (synchronous, active low) clears counters, window, output valid and config to defaults
// the line store is not cleared; no clearing pass is needed
module scale_space_extremum_detect
    import ssed_pkg::*;
#(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // below_sample, center_sample, above_sample
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    // mode
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // found, row, col
    output logic [OUT_DATA_BITS-1:0]               m_axis_tdata,
    // kind
    output logic [1:0]                             m_axis_tuser,
    output logic                                   m_axis_tlast,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]                i_cfg_index,
    input  logic [THR_BITS-1:0]                    i_cfg_data
);

    localparam int SB = SAMPLE_BITS;
    localparam int TB = 3 * SB;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int EW = WW + HEIGHT_BITS;
    localparam int MW = SB + THR_BITS + 1;

    // configuration
    logic [FW_BITS-1:0]     r_frame_width;
    logic [HEIGHT_BITS-1:0] r_frame_height;
    logic [THR_BITS-1:0]    r_small_threshold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width     <= FRAME_WIDTH_RST;
            r_frame_height    <= FRAME_HEIGHT_RST;
            r_small_threshold <= THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:     r_frame_width     <= i_cfg_data[FW_BITS-1:0];
                CFG_FRAME_HEIGHT:    r_frame_height    <= i_cfg_data[HEIGHT_BITS-1:0];
                CFG_SMALL_THRESHOLD: r_small_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped frame size
    logic [WW-1:0]          eff_w;
    logic [HEIGHT_BITS-1:0] eff_h;
    logic [EW-1:0]          fw_ext;

    assign fw_ext = EW'(r_frame_width);

    always_comb begin
        if (fw_ext < EW'(3)) begin
            eff_w = WW'(3);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = fw_ext[WW-1:0];
        end
        if (r_frame_height < HEIGHT_BITS'(3)) begin
            eff_h = HEIGHT_BITS'(3);
        end else if (r_frame_height > HEIGHT_BITS'(MAX_HEIGHT)) begin
            eff_h = HEIGHT_BITS'(MAX_HEIGHT);
        end else begin
            eff_h = r_frame_height;
        end
    end

    // position state
    logic [ROW_BITS-1:0] r_in_row, n_in_row;
    logic [CW-1:0]       r_in_col, n_in_col;
    logic [PW-1:0]       r_pend, n_pend;

    // stage 1
    t_s1_ctrl          r_s1, n_s1;
    logic [CW-1:0]     r_s1_addr, n_addr;
    logic [CW-1:0]     r_s1_cm, n_cm;
    logic [TB-1:0]     r_s1_cur;
    logic              r_fwd_hit;
    logic [2*TB-1:0]   r_fwd_data;

    logic signed [SB-1:0] r_win [9][3];
    logic signed [SB-1:0] n_win [9][3];

    logic r_out_valid;
    logic r_out_found;
    t_kind r_out_kind;
    logic [ROW_BITS-1:0] r_out_row;
    logic [COL_OUT_BITS-1:0] r_out_col;
    logic r_out_last;

    logic advance, in_fire, s1_fire, ram_we;
    logic [2*TB-1:0] ram_rdata, rdata, wdata;

    assign advance = !(r_s1.valid && r_s1.res && r_out_valid && !m_axis_tready);
    assign s_axis_tready = advance;
    assign in_fire = s_axis_tvalid && advance;
    assign s1_fire = advance && r_s1.valid;
    assign ram_we  = s1_fire && r_s1.write;

    // item decode
    always_comb begin
        logic [ROW_BITS-1:0] px_r;
        logic [CW-1:0]       px_c;
        logic [WW-1:0]       w_m1;
        logic [HEIGHT_BITS-1:0] h_m1, h_m2;
        logic [PW-1:0]       fl_c, fl_cm;
        logic                pend_nz;

        pend_nz = (r_pend != '0);
        px_r    = pend_nz ? '0 : r_in_row;
        px_c    = pend_nz ? '0 : r_in_col;
        w_m1    = eff_w - WW'(1);
        h_m1    = eff_h - HEIGHT_BITS'(1);
        h_m2    = eff_h - HEIGHT_BITS'(2);
        fl_c    = PW'(eff_w) + PW'(1) - r_pend;
        fl_cm   = fl_c - PW'(1);

        n_s1     = '0;
        n_addr   = '0;
        n_cm     = '0;
        n_in_row = r_in_row;
        n_in_col = r_in_col;
        n_pend   = r_pend;

        if (s_axis_tuser == MODE_PIXEL) begin
            n_s1.valid = 1'b1;
            n_s1.shift = 1'b1;
            n_s1.write = 1'b1;
            n_addr     = px_c;
            if (px_c == '0 && px_r >= ROW_BITS'(2)) begin
                n_s1.res     = 1'b1;
                n_s1.use_pre = 1'b1;
                n_s1.rm      = px_r - ROW_BITS'(2);
                n_cm         = w_m1[CW-1:0];
            end else if (px_c != '0 && px_r != '0) begin
                n_s1.res = 1'b1;
                n_s1.rm  = px_r - ROW_BITS'(1);
                n_cm     = px_c - CW'(1);
            end
            n_pend = '0;
            if (WW'(px_c) + WW'(1) >= eff_w) begin
                n_in_col = '0;
                if (HEIGHT_BITS'(px_r) + HEIGHT_BITS'(1) >= eff_h) begin
                    n_in_row = '0;
                    n_pend   = PW'(eff_w) + PW'(1);
                end else begin
                    n_in_row = px_r + ROW_BITS'(1);
                end
            end else begin
                n_in_row = px_r;
                n_in_col = px_c + CW'(1);
            end
        end else if (pend_nz) begin
            n_s1.valid = 1'b1;
            n_s1.res   = 1'b1;
            n_pend     = r_pend - PW'(1);
            priority if (r_pend >= PW'(eff_w) + PW'(1)) begin
                n_s1.shift    = 1'b1;
                n_s1.zero_bot = 1'b1;
                n_s1.use_pre  = 1'b1;
                n_s1.rm       = h_m2[ROW_BITS-1:0];
                n_cm          = w_m1[CW-1:0];
            end else if (r_pend >= PW'(2)) begin
                n_s1.shift    = 1'b1;
                n_s1.zero_bot = 1'b1;
                n_addr        = fl_c[CW-1:0];
                n_s1.rm       = h_m1[ROW_BITS-1:0];
                n_cm          = fl_cm[CW-1:0];
            end else begin
                n_s1.use_pre = 1'b1;
                n_s1.last    = 1'b1;
                n_s1.rm      = h_m1[ROW_BITS-1:0];
                n_cm         = w_m1[CW-1:0];
            end
        end

        n_s1.tmir = (n_s1.rm == '0);
        n_s1.bmir = (HEIGHT_BITS'(n_s1.rm) + HEIGHT_BITS'(1) >= eff_h);
        n_s1.lmir = (n_cm == '0);
        n_s1.rmir = (WW'(n_cm) + WW'(1) >= eff_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_row <= '0;
            r_in_col <= '0;
            r_pend   <= '0;
            r_s1     <= '0;
            r_fwd_hit <= 1'b0;
        end else if (advance) begin
            if (in_fire) begin
                r_in_row <= n_in_row;
                r_in_col <= n_in_col;
                r_pend   <= n_pend;
            end
            r_s1      <= in_fire ? n_s1 : '0;
            r_fwd_hit <= in_fire && ram_we && (r_s1_addr == n_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_addr  <= n_addr;
            r_s1_cm    <= n_cm;
            r_s1_cur   <= s_axis_tdata[TB-1:0];
            r_fwd_data <= wdata;
        end
    end

    // line store: low half the older row, high half the newer row
    ssed_ram #(
        .WIDTH (2 * TB),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (wdata),
        .i_re    (in_fire),
        .i_raddr (n_addr),
        .o_rdata (ram_rdata)
    );

    assign rdata = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign wdata = {r_s1_cur, rdata[2*TB-1:TB]};

    // window shift and decision
    logic    dec_found;
    t_kind   dec_kind;

    always_comb begin
        logic signed [SB-1:0] wsel [9][3];
        logic signed [SB-1:0] v, nb;
        logic [1:0]           cols [3];
        logic [1:0]           rows [3];
        logic [3:0]           idx;
        logic [SB:0]          v_ext, mag;
        logic                 is_max, is_min;

        for (int k = 0; k < 9; k++) begin
            for (int z = 0; z < 3; z++) begin
                n_win[k][z] = r_win[k][z];
            end
        end
        if (r_s1.shift) begin
            for (int k = 0; k < 6; k++) begin
                for (int z = 0; z < 3; z++) begin
                    n_win[k][z] = r_win[k+3][z];
                end
            end
            for (int z = 0; z < 3; z++) begin
                n_win[6][z] = rdata[z*SB +: SB];
                n_win[7][z] = rdata[TB + z*SB +: SB];
                n_win[8][z] = r_s1.zero_bot ? '0 : r_s1_cur[z*SB +: SB];
            end
        end

        for (int k = 0; k < 9; k++) begin
            for (int z = 0; z < 3; z++) begin
                wsel[k][z] = r_s1.use_pre ? r_win[k][z] : n_win[k][z];
            end
        end

        if (r_s1.use_pre) begin
            cols[0] = 2'd1;
            cols[1] = 2'd2;
            cols[2] = 2'd1;
        end else begin
            cols[0] = r_s1.lmir ? 2'd2 : 2'd0;
            cols[1] = 2'd1;
            cols[2] = r_s1.rmir ? 2'd0 : 2'd2;
        end
        rows[0] = r_s1.tmir ? 2'd2 : 2'd0;
        rows[1] = 2'd1;
        rows[2] = r_s1.bmir ? 2'd0 : 2'd2;

        idx    = 4'(cols[1] * 3 + 1);
        v      = wsel[idx][1];
        is_max = 1'b1;
        is_min = 1'b1;
        for (int z = 0; z < 3; z++) begin
            for (int y = 0; y < 3; y++) begin
                for (int x = 0; x < 3; x++) begin
                    idx = 4'(cols[x] * 3 + rows[y]);
                    nb  = wsel[idx][z];
                    if (!(z == 1 && y == 1 && x == 1)) begin
                        if (nb > v) begin
                            is_max = 1'b0;
                        end
                        if (v > nb) begin
                            is_min = 1'b0;
                        end
                    end
                end
            end
        end

        v_ext = {v[SB-1], v};
        mag   = v[SB-1] ? -v_ext : v_ext;
        dec_found = (MW'(mag) >= MW'(r_small_threshold)) && (is_max || is_min);
        if (!dec_found) begin
            dec_kind = KIND_MAX;
        end else if (is_max && is_min) begin
            dec_kind = KIND_BOTH;
        end else if (is_max) begin
            dec_kind = KIND_MAX;
        end else begin
            dec_kind = KIND_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                for (int z = 0; z < 3; z++) begin
                    r_win[k][z] <= '0;
                end
            end
        end else if (s1_fire && r_s1.shift) begin
            r_win <= n_win;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1.res) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1.res) begin
            r_out_found <= dec_found;
            r_out_kind  <= dec_kind;
            r_out_row   <= r_s1.rm;
            r_out_col   <= COL_OUT_BITS'(r_s1_cm);
            r_out_last  <= r_s1.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_col, r_out_row, r_out_found};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

endmodule

/* design/ssed_checker.sv */
module ssed_checker
    import ssed_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_m_tvalid,
    input logic                     i_m_tready,
    input logic [OUT_DATA_BITS-1:0] i_m_tdata,
    input logic [1:0]               i_m_tuser,
    input logic                     i_m_tlast
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // no extremum means kind stays at its zero code
    a_kind_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tdata[0] |-> i_m_tuser == KIND_MAX)
        else $error("kind set without extremum");

    // a frame end transaction is never followed at once by another frame end
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tready && i_m_tlast |=> !(i_m_tvalid && i_m_tlast))
        else $error("back-to-back frame end");

endmodule

bind scale_space_extremum_detect ssed_checker u_ssed_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser),
    .i_m_tlast  (m_axis_tlast)
);
